@@ src/iir4_pkg.sv @@
package iir4_pkg;

	// Defaults of the top-level parameters
	localparam int SAMPLE_BITS_DEF = 12;
	localparam int COEF_FRAC_DEF   = 28;
	localparam int HIST_FRAC_DEF   = 12;

	localparam int COEF_W     = 32;
	localparam int HIST_W     = 40;
	localparam int HIST_DEPTH = 4;
	// stored outputs are split here so that each feedback product stays near 32x20
	localparam int SPLIT      = 20;
	localparam int DAC_W      = 12;
	localparam logic [DAC_W-1:0] DAC_MAX = {DAC_W{1'b1}};

	localparam int DATA_W = 32;
	localparam int ADDR_W = 5;

	localparam logic signed [HIST_W-1:0] Y_MAX = {1'b0, {(HIST_W-1){1'b1}}};
	localparam logic signed [HIST_W-1:0] Y_MIN = {1'b1, {(HIST_W-1){1'b0}}};

	typedef enum logic [2:0] {
		REG_B0 = 3'd0,
		REG_B1 = 3'd1,
		REG_B2 = 3'd2,
		REG_A1 = 3'd3,
		REG_A2 = 3'd4,
		REG_A3 = 3'd5,
		REG_A4 = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] b0;
		logic signed [COEF_W-1:0] b1;
		logic signed [COEF_W-1:0] b2;
		logic signed [COEF_W-1:0] a1;
		logic signed [COEF_W-1:0] a2;
		logic signed [COEF_W-1:0] a3;
		logic signed [COEF_W-1:0] a4;
	} coef_t;

	localparam logic signed [COEF_W-1:0] B0_RST = 32'sd3996192;
	localparam logic signed [COEF_W-1:0] B1_RST = -32'sd7236750;
	localparam logic signed [COEF_W-1:0] B2_RST = 32'sd9948044;
	localparam logic signed [COEF_W-1:0] A1_RST = 32'sd896223640;
	localparam logic signed [COEF_W-1:0] A2_RST = -32'sd1181630459;
	localparam logic signed [COEF_W-1:0] A3_RST = 32'sd722527758;
	localparam logic signed [COEF_W-1:0] A4_RST = -32'sd172575440;

endpackage

@@ src/iir4_regs.sv @@
module iir4_regs import iir4_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output coef_t             coef
);

	coef_t    coef_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign coef   = coef_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.b0 <= B0_RST;
			coef_q.b1 <= B1_RST;
			coef_q.b2 <= B2_RST;
			coef_q.a1 <= A1_RST;
			coef_q.a2 <= A2_RST;
			coef_q.a3 <= A3_RST;
			coef_q.a4 <= A4_RST;
		end else if (wr_en) begin
			case (idx)
				REG_B0: coef_q.b0 <= $signed(pwdata);
				REG_B1: coef_q.b1 <= $signed(pwdata);
				REG_B2: coef_q.b2 <= $signed(pwdata);
				REG_A1: coef_q.a1 <= $signed(pwdata);
				REG_A2: coef_q.a2 <= $signed(pwdata);
				REG_A3: coef_q.a3 <= $signed(pwdata);
				REG_A4: coef_q.a4 <= $signed(pwdata);
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_B0: prdata = coef_q.b0;
			REG_B1: prdata = coef_q.b1;
			REG_B2: prdata = coef_q.b2;
			REG_A1: prdata = coef_q.a1;
			REG_A2: prdata = coef_q.a2;
			REG_A3: prdata = coef_q.a3;
			REG_A4: prdata = coef_q.a4;
			default: prdata = '0;
		endcase
	end

endmodule

@@ src/iir4_dp.sv @@
module iir4_dp import iir4_pkg::*; #(
	parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
	parameter int COEF_FRAC_BITS = COEF_FRAC_DEF,
	parameter int HIST_FRAC_BITS = HIST_FRAC_DEF
) (
	input  coef_t                                   coef,
	input  logic [SAMPLE_BITS-1:0]                  x0,
	input  logic [HIST_DEPTH-1:0][SAMPLE_BITS-1:0]  xh,
	input  logic [HIST_DEPTH-1:0][HIST_W-1:0]       yh,
	output logic signed [HIST_W-1:0]                y_new,
	output logic [DAC_W-1:0]                        dac,
	output logic                                    clip
);

	localparam int XS_W  = SAMPLE_BITS + 1;
	localparam int PB_W  = COEF_W + XS_W + 1;
	localparam int NUM_W = PB_W + 2;
	localparam int HI_W  = HIST_W - SPLIT;
	localparam int PH_W  = COEF_W + HI_W;
	localparam int PL_W  = COEF_W + SPLIT + 1;
	localparam int FB_W  = COEF_W + HIST_W + 3;
	localparam int NS_W  = NUM_W + HIST_FRAC_BITS + 1;
	localparam int SUM_W = ((FB_W > NS_W) ? FB_W : NS_W) + 1;
	// the sum carries COEF_FRAC_BITS + HIST_FRAC_BITS fraction bits
	localparam int RND_SH = COEF_FRAC_BITS + HIST_FRAC_BITS;

	logic [XS_W-1:0]          xs04, xs13;
	logic signed [PB_W-1:0]   pb0, pb1, pb2;
	logic signed [NUM_W-1:0]  num;
	logic signed [COEF_W-1:0] af [HIST_DEPTH];
	logic signed [PH_W-1:0]   ph [HIST_DEPTH];
	logic signed [PL_W-1:0]   pl [HIST_DEPTH];
	logic signed [SUM_W-1:0]  acc, rnd, q;
	logic [HIST_W-1:0]        neg_mag;
	logic signed [HIST_W-1:0] ytr;

	// symmetric numerator: taps 0/4 and 1/3 share a coefficient
	assign xs04 = XS_W'(x0) + XS_W'(xh[3]);
	assign xs13 = XS_W'(xh[0]) + XS_W'(xh[2]);
	assign pb0  = coef.b0 * $signed({1'b0, xs04});
	assign pb1  = coef.b1 * $signed({1'b0, xs13});
	assign pb2  = coef.b2 * $signed({2'b00, xh[1]});
	assign num  = NUM_W'(pb0) + NUM_W'(pb1) + NUM_W'(pb2);

	assign af[0] = coef.a1;
	assign af[1] = coef.a2;
	assign af[2] = coef.a3;
	assign af[3] = coef.a4;

	always_comb begin
		for (int k = 0; k < HIST_DEPTH; k++) begin
			ph[k] = af[k] * $signed(yh[k][HIST_W-1:SPLIT]);
			pl[k] = af[k] * $signed({1'b0, yh[k][SPLIT-1:0]});
		end
	end

	always_comb begin
		acc = SUM_W'(num) <<< HIST_FRAC_BITS;
		for (int k = 0; k < HIST_DEPTH; k++) begin
			acc = acc + (SUM_W'(ph[k]) <<< SPLIT) + SUM_W'(pl[k]);
		end
	end

	// round half up, then saturate to the stored width
	assign rnd = acc + (SUM_W'(1) << (RND_SH - 1));
	assign q   = rnd >>> RND_SH;

	always_comb begin
		if (q > SUM_W'(Y_MAX)) begin
			y_new = Y_MAX;
		end else if (q < SUM_W'(Y_MIN)) begin
			y_new = Y_MIN;
		end else begin
			y_new = q[HIST_W-1:0];
		end
	end

	// truncate toward zero, then clamp to the DAC range
	assign neg_mag = -y_new;
	assign ytr     = y_new >>> HIST_FRAC_BITS;

	always_comb begin
		if (y_new[HIST_W-1]) begin
			dac  = '0;
			clip = |(neg_mag >> HIST_FRAC_BITS);
		end else if (ytr > $signed(HIST_W'(DAC_MAX))) begin
			dac  = DAC_MAX;
			clip = 1'b1;
		end else begin
			dac  = ytr[DAC_W-1:0];
			clip = 1'b0;
		end
	end

endmodule

@@ src/iir_order4_direct_form1_core.sv @@
// Fourth-order direct form I IIR filter, one sample per beat.
// A sample passes the input register, then the result register, before result_valid.
// Throughput: 1 sample per cycle unless stalled; the feedback sum over the four stored outputs
// closes within the single stage between the input register and the history/result registers.
// Reset: arst_n clears both histories, the pipeline valids and loads the default coefficients.
module iir_order4_direct_form1_core import iir4_pkg::*; #(
	parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
	parameter int COEF_FRAC_BITS = COEF_FRAC_DEF,
	parameter int HIST_FRAC_BITS = HIST_FRAC_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [ADDR_W-1:0]      paddr,
	input  logic [DATA_W-1:0]      pwdata,
	output logic [DATA_W-1:0]      prdata,
	output logic                   pready,
	input  logic                   sample_valid,
	output logic                   sample_ready,
	input  logic [SAMPLE_BITS-1:0] sample,
	output logic                   result_valid,
	input  logic                   result_ready,
	output logic [DAC_W-1:0]       dac_value,
	output logic                   clipped
);

	coef_t coef;

	logic                                  vld_s1;
	logic [SAMPLE_BITS-1:0]                x_s1;
	logic [HIST_DEPTH-1:0][SAMPLE_BITS-1:0] xh_q;
	logic [HIST_DEPTH-1:0][HIST_W-1:0]     yh_q;
	logic                                  out_vld_q;
	logic [DAC_W-1:0]                      dac_q;
	logic                                  clip_q;

	logic                    adv;
	logic                    fire;
	logic signed [HIST_W-1:0] y_new;
	logic [DAC_W-1:0]        dac;
	logic                    clip;

	iir4_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.coef   (coef)
	);

	iir4_dp #(
		.SAMPLE_BITS   (SAMPLE_BITS),
		.COEF_FRAC_BITS(COEF_FRAC_BITS),
		.HIST_FRAC_BITS(HIST_FRAC_BITS)
	) u_dp (
		.coef (coef),
		.x0   (x_s1),
		.xh   (xh_q),
		.yh   (yh_q),
		.y_new(y_new),
		.dac  (dac),
		.clip (clip)
	);

	// result register free or being emptied this cycle
	assign adv          = !out_vld_q || result_ready;
	assign fire         = vld_s1 && adv;
	assign sample_ready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (sample_ready) begin
			vld_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_ready && sample_valid) begin
			x_s1 <= sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xh_q <= '0;
			yh_q <= '0;
		end else if (fire) begin
			for (int k = HIST_DEPTH - 1; k > 0; k--) begin
				xh_q[k] <= xh_q[k-1];
				yh_q[k] <= yh_q[k-1];
			end
			xh_q[0] <= x_s1;
			yh_q[0] <= y_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			dac_q  <= dac;
			clip_q <= clip;
		end
	end

	assign result_valid = out_vld_q;
	assign dac_value    = dac_q;
	assign clipped      = clip_q;

	a_s1_moves: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && adv |=> out_vld_q)
		else $error("stage 1 item did not reach the result register");

	a_in_capture: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready |=> vld_s1 && (x_s1 == $past(sample)))
		else $error("accepted sample not held in stage 1");

	a_hist_shift: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> (xh_q[0] == $past(x_s1)) && (xh_q[1] == $past(xh_q[0]))
			&& (yh_q[1] == $past(yh_q[0])))
		else $error("history did not shift on a processed sample");

	a_hist_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(xh_q) && $stable(yh_q))
		else $error("history changed without a processed sample");

	a_clip_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && clip_q |-> (dac_q == '0) || (dac_q == DAC_MAX))
		else $error("clipped result not at a rail");

endmodule
